### sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KEY_W            = 21;
	localparam int STATUS_W         = 3;
	localparam int CAPACITY_DEF     = 256;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

	// broadcast from the control to every cell during the execute cycle
	typedef struct packed {
		logic             ins;   // absent key, room left: open a gap and write
		logic             rep;   // present key: overwrite payload
		logic             look;  // lookup: flag the matching cell
		logic [KEY_W-1:0] key;
	} skt_ctrl_t;

endpackage

### sv/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key and payload, compares against the broadcast
// key and takes its lower neighbour's entry when a gap opens below it.
// ----------------------------------------------------------------------------
module skt_cell #(
	parameter int IDX          = 0,
	parameter int CNT_W        = 9,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  skt_pkg::skt_ctrl_t       ctrl,
	input  logic [PAYLOAD_BITS-1:0]  pay_new,
	input  logic [CNT_W-1:0]         count,
	input  logic                     prev_ge,
	input  logic [skt_pkg::KEY_W-1:0] prev_key,
	input  logic [PAYLOAD_BITS-1:0]  prev_pay,
	output logic                     ge,
	output logic                     eq,
	output logic [skt_pkg::KEY_W-1:0] key,
	output logic [PAYLOAD_BITS-1:0]  pay,
	output logic                     match
);
	import skt_pkg::*;

	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    match_q;
	logic                    occupied;
	logic                    at_end;
	logic                    at_pos;

	assign occupied = CNT_W'(IDX) < count;
	assign at_end   = CNT_W'(IDX) == count;
	assign ge       = occupied && (key_q >= ctrl.key);
	assign eq       = occupied && (key_q == ctrl.key);
	assign at_pos   = (ge || at_end) && !prev_ge;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_ge) begin
				key_q <= prev_key;
				pay_q <= prev_pay;
			end else if (at_pos) begin
				key_q <= ctrl.key;
				pay_q <= pay_new;
			end
		end else if (ctrl.rep && eq) begin
			pay_q <= pay_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= ctrl.look && eq;
		end
	end

	assign key   = key_q;
	assign pay   = pay_q;
	assign match = match_q;

endmodule

### sv/sorted_key_table_insert_lookup_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup_top
// Sorted key/payload table built as a row of shifting compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (command, lookup_key, payload_in) is taken at a
//   rising edge with start high and busy low. busy is high for the one
//   execute cycle that follows.
//   Result channel: status, payload_out and entry_count are valid for
//   exactly one cycle, marked by done, which is registered from the execute
//   cycle. The receiver cannot stall; results are never held.
//   A new item cannot be taken during the execute cycle, in which every
//   cell compares its key against the broadcast key and shifts or writes in
//   place; the next item is taken in the cycle that shows the previous
//   result.
//   Insert of a present key replaces its payload; of an absent key opens a
//   gap at the first larger key, or reports full when every cell is used.
//   Lookup returns the stored payload on a hit, zero on a miss.
//   Reset: the table is empty (count zero), no result pending. Cell
//   contents are not cleared; only cells below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_lookup_top #(
	parameter int CAPACITY     = skt_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_W        = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [skt_pkg::KEY_W-1:0]    lookup_key,
	input  logic [PAYLOAD_BITS-1:0]      payload_in,
	output logic                         done,
	output logic [skt_pkg::STATUS_W-1:0] status,
	output logic [PAYLOAD_BITS-1:0]      payload_out,
	output logic [CNT_W-1:0]             entry_count
);
	import skt_pkg::*;

	logic                    exec_q;
	logic                    done_q;
	logic                    cmd_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0]        count_q;
	logic [STATUS_W-1:0]     status_q;

	logic                    found;
	logic                    full;
	skt_ctrl_t               ctrl;

	logic                    cell_ge    [CAPACITY];
	logic [CAPACITY-1:0]     cell_eq;
	logic [KEY_W-1:0]        cell_key   [CAPACITY];
	logic [PAYLOAD_BITS-1:0] cell_pay   [CAPACITY];
	logic                    cell_match [CAPACITY];

	assign busy  = exec_q;
	assign found = |cell_eq;
	assign full  = count_q == CNT_W'(CAPACITY);

	always_comb begin
		ctrl.key  = key_q;
		ctrl.look = exec_q && (cmd_q == CMD_LOOKUP);
		ctrl.rep  = exec_q && (cmd_q == CMD_INSERT) && found;
		ctrl.ins  = exec_q && (cmd_q == CMD_INSERT) && !found && !full;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			skt_cell #(
				.IDX(i), .CNT_W(CNT_W), .PAYLOAD_BITS(PAYLOAD_BITS)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .pay_new(pay_q),
				.count(count_q), .prev_ge(1'b0), .prev_key('0), .prev_pay('0),
				.ge(cell_ge[i]), .eq(cell_eq[i]), .key(cell_key[i]),
				.pay(cell_pay[i]), .match(cell_match[i])
			);
		end else begin : g_next
			skt_cell #(
				.IDX(i), .CNT_W(CNT_W), .PAYLOAD_BITS(PAYLOAD_BITS)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .pay_new(pay_q),
				.count(count_q), .prev_ge(cell_ge[i-1]), .prev_key(cell_key[i-1]),
				.prev_pay(cell_pay[i-1]),
				.ge(cell_ge[i]), .eq(cell_eq[i]), .key(cell_key[i]),
				.pay(cell_pay[i]), .match(cell_match[i])
			);
		end
	end

	// at most one cell flags a match: one-hot select of the hit payload
	always_comb begin
		payload_out = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			payload_out = payload_out | (cell_pay[i] & {PAYLOAD_BITS{cell_match[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= command;
			key_q <= lookup_key;
			pay_q <= payload_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q   <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			status_q <= ST_INSERTED;
		end else begin
			exec_q <= start && !busy;
			done_q <= exec_q;
			if (exec_q) begin
				if (cmd_q == CMD_LOOKUP) begin
					status_q <= found ? ST_HIT : ST_MISS;
				end else if (found) begin
					status_q <= ST_REPLACED;
				end else if (full) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_INSERTED;
					count_q  <= count_q + CNT_W'(1);
				end
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = count_q;

	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q |=> done_q)
		else $error("execute cycle not followed by result");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(exec_q && done_q))
		else $error("execute and result cycles overlap");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full reported with room left");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_eq))
		else $error("key present in more than one cell");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key table. Items go in on start/busy in
// bursts with random gaps. Each result is checked against a behavioural copy
// of the table kept in the bench. A short directed table comes first: empty
// table, extreme keys and payloads, replace, hit and miss. Random traffic
// follows on a small key pool plus fresh keys. Later on, the table is filled
// to capacity so that replaces under a full table and full rejects occur.
// ----------------------------------------------------------------------------
module tb;
	import skt_pkg::*;

	localparam int CAP       = CAPACITY_DEF;
	localparam int PW        = PAYLOAD_BITS_DEF;
	localparam int CNT_W     = $clog2(CAP + 1);
	localparam int KEY_MAX   = (1 << KEY_W) - 1;
	localparam int N_RANDOM  = 1500;
	localparam int FILL_FROM = 900;
	localparam int POOL_N    = 64;
	localparam int LIMIT     = 200000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PW-1:0]       payload;
		logic [CNT_W-1:0]    count;
	} result_t;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
		logic [PW-1:0]    pay;
		logic             typed;
		result_t          res;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                command;
	logic [KEY_W-1:0]    lookup_key;
	logic [PW-1:0]       payload_in;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [PW-1:0]       payload_out;
	logic [CNT_W-1:0]    entry_count;

	// shadow copy of the table
	logic [KEY_W-1:0] tbl_key [CAP];
	logic [PW-1:0]    tbl_pay [CAP];
	int               tbl_count;

	result_t          pending_results[$];
	row_t             directed_rows[$];
	logic [KEY_W-1:0] key_pool [POOL_N];
	int               errors;
	int               items_sent;
	int               results_seen;
	int               stat_seen [5];
	int               burst_left;
	int               cycles;

	sorted_key_table_insert_lookup_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.lookup_key  (lookup_key),
		.payload_in  (payload_in),
		.done        (done),
		.status      (status),
		.payload_out (payload_out),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic result_t table_apply(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [PW-1:0] pay);
		result_t r;
		int      pos;
		int      j;
		logic    found;
		r = '0;
		for (pos = 0; pos < tbl_count; pos++)
			if (tbl_key[pos] >= key)
				break;
		found = (pos < tbl_count) && (tbl_key[pos] == key);
		if (cmd == CMD_LOOKUP) begin
			if (found) begin
				r.status  = ST_HIT;
				r.payload = tbl_pay[pos];
			end else begin
				r.status = ST_MISS;
			end
		end else if (found) begin
			tbl_pay[pos] = pay;
			r.status     = ST_REPLACED;
		end else if (tbl_count >= CAP) begin
			r.status = ST_FULL;
		end else begin
			for (j = tbl_count; j > pos; j--) begin
				tbl_key[j] = tbl_key[j-1];
				tbl_pay[j] = tbl_pay[j-1];
			end
			tbl_key[pos] = key;
			tbl_pay[pos] = pay;
			tbl_count++;
			r.status = ST_INSERTED;
		end
		r.count = tbl_count[CNT_W-1:0];
		return r;
	endfunction

	function automatic row_t mk_row(input logic cmd, input int key, input logic [PW-1:0] pay,
			input logic typed, input logic [STATUS_W-1:0] st, input logic [PW-1:0] po,
			input int cnt);
		row_t r;
		r.cmd         = cmd;
		r.key         = key[KEY_W-1:0];
		r.pay         = pay;
		r.typed       = typed;
		r.res.status  = st;
		r.res.payload = po;
		r.res.count   = cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [PW-1:0] rand_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [PW-1:0] pay, input logic typed, input result_t want);
		result_t predicted;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		start      <= 1'b1;
		command    <= cmd;
		lookup_key <= key;
		payload_in <= pay;
		do @(posedge clk); while (busy);
		predicted = table_apply(cmd, key, pay);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (status <= ST_MISS)
				stat_seen[status]++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected result status=%0d payload=%h count=%0d",
						status, payload_out, entry_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || payload_out !== want.payload
						|| entry_count !== want.count) begin
					errors++;
					if (errors <= 10)
						$display("tb: mismatch on result %0d: exp %0d/%h/%0d got %0d/%h/%0d",
							results_seen, want.status, want.payload, want.count,
							status, payload_out, entry_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int               i;
		logic             cmd;
		logic [KEY_W-1:0] key;
		row_t             row;

		arst_n     <= 1'b0;
		start      <= 1'b0;
		command    <= CMD_INSERT;
		lookup_key <= '0;
		payload_in <= '0;
		tbl_count    = 0;
		items_sent   = 0;
		burst_left   = 0;

		key_pool[0] = '0;
		key_pool[1] = KEY_MAX[KEY_W-1:0];
		key_pool[2] = 21'h10FFFF;
		key_pool[3] = 21'h110000;
		for (i = 4; i < POOL_N; i++)
			key_pool[i] = KEY_W'($urandom_range(0, KEY_MAX));

		// cmd, key, payload_in, typed, status, payload_out, count
		directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 32'h0, 1'b1, ST_MISS, 32'h0, 0));
		directed_rows.push_back(mk_row(CMD_LOOKUP, KEY_MAX, 32'hFFFFFFFF, 1'b1, ST_MISS,
			32'h0, 0));
		directed_rows.push_back(mk_row(CMD_INSERT, 'h100, 32'hA5A5A5A5, 1'b1, ST_INSERTED,
			32'h0, 1));
		directed_rows.push_back(mk_row(CMD_INSERT, KEY_MAX, 32'hFFFFFFFF, 1'b1, ST_INSERTED,
			32'h0, 2));
		directed_rows.push_back(mk_row(CMD_INSERT, 0, 32'h0, 1'b1, ST_INSERTED, 32'h0, 3));
		directed_rows.push_back(mk_row(CMD_INSERT, 'h10FFFF, 32'h12345678, 1'b1, ST_INSERTED,
			32'h0, 4));
		directed_rows.push_back(mk_row(CMD_INSERT, 'h110000, 32'h5A5A5A5A, 1'b1, ST_INSERTED,
			32'h0, 5));
		directed_rows.push_back(mk_row(CMD_LOOKUP, KEY_MAX, 32'h0, 1'b1, ST_HIT,
			32'hFFFFFFFF, 5));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 32'hFFFFFFFF, 1'b1, ST_HIT, 32'h0, 5));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 'h10FFFF, 32'h0, 1'b1, ST_HIT,
			32'h12345678, 5));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 'h101, 32'h0, 1'b1, ST_MISS, 32'h0, 5));
		directed_rows.push_back(mk_row(CMD_INSERT, 'h100, 32'h0, 1'b1, ST_REPLACED, 32'h0, 5));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 'h100, 32'hDEADBEEF, 1'b1, ST_HIT,
			32'h0, 5));
		directed_rows.push_back(mk_row(CMD_INSERT, 0, 32'hFFFFFFFF, 1'b1, ST_REPLACED,
			32'h0, 5));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 32'hDEADBEEF, 1'b1, ST_HIT,
			32'hFFFFFFFF, 5));
		directed_rows.push_back(mk_row(CMD_INSERT, 'h50, 32'h11111111, 1'b0, ST_INSERTED,
			32'h0, 0));
		directed_rows.push_back(mk_row(CMD_INSERT, 'h1FFFFE, 32'h22222222, 1'b0, ST_INSERTED,
			32'h0, 0));
		directed_rows.push_back(mk_row(CMD_INSERT, 1, 32'h33333333, 1'b0, ST_INSERTED,
			32'h0, 0));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 'h1FFFFE, 32'h0, 1'b0, ST_INSERTED,
			32'h0, 0));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 'h110000, 32'h0, 1'b0, ST_INSERTED,
			32'h0, 0));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 1, 32'h0, 1'b0, ST_INSERTED, 32'h0, 0));
		directed_rows.push_back(mk_row(CMD_LOOKUP, 'h0FFFFF, 32'h0, 1'b0, ST_INSERTED,
			32'h0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			send_item(row.cmd, row.key, row.pay, row.typed, row.res);
		end

		// mixed traffic, then fill to capacity and keep hammering the full table
		for (i = 0; i < N_RANDOM; i++) begin
			if (i >= FILL_FROM && tbl_count < CAP) begin
				cmd = CMD_INSERT;
				key = KEY_W'($urandom_range(0, KEY_MAX));
			end else begin
				cmd = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_LOOKUP;
				key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_N - 1)]
					: KEY_W'($urandom_range(0, KEY_MAX));
			end
			send_item(cmd, key, rand_payload(), 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("tb: %0d items sent, %0d results checked, table ends with %0d entries",
			items_sent, results_seen, tbl_count);
		$display("tb: inserted %0d, replaced %0d, full %0d, hit %0d, miss %0d",
			stat_seen[ST_INSERTED], stat_seen[ST_REPLACED], stat_seen[ST_FULL],
			stat_seen[ST_HIT], stat_seen[ST_MISS]);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: %0d mismatches", errors);
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
